@@ design/gn3_pkg.sv @@
package gn3_pkg;

   localparam int unsigned COORD_W    = 32;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned NOISE_W    = 20;
   localparam int unsigned WRAP_W     = 10;
   localparam int unsigned WRAP_STEPS = 7;

   localparam logic [BYTE_W-1:0] CELL_MASK_RESET = 8'hFF;
   localparam int signed         NOISE_LIMIT     = 262144;

   // fade polynomial 6t^5 - 15t^4 + 10t^3
   localparam int unsigned FADE_C6  = 6;
   localparam int unsigned FADE_C10 = 10;
   localparam int unsigned FADE_C15 = 15;

   // gradient selection codes
   localparam logic [3:0] H_U_Y  = 4'd8;
   localparam logic [3:0] H_V_Y  = 4'd4;
   localparam logic [3:0] H_V_X0 = 4'd12;
   localparam logic [3:0] H_V_X1 = 4'd14;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_EVAL  = 1'b1
   } op_type;

   // control carried down the lookup stages; table writes ride with the beat
   typedef struct packed {
      logic              valid;
      logic              is_write;
      logic [BYTE_W-1:0] windex;
      logic [BYTE_W-1:0] wvalue;
   } beat_ctl_type;

   // index modulo table depth by conditional subtraction (depth >= 8)
   function automatic logic [WRAP_W-1:0] wrap_index(input logic [WRAP_W-1:0] raw,
                                                    input int unsigned depth);
      logic [WRAP_W-1:0] acc;
      logic [16:0]       lim;
      acc = raw;
      lim = '0;
      for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
         lim = 17'(depth << k);
         if ({7'd0, acc} >= lim) begin
            acc = acc - lim[WRAP_W-1:0];
         end
      end
      return acc;
   endfunction

   function automatic logic signed [COORD_W-1:0] grad_dot(
      input logic [3:0]                 h,
      input logic signed [COORD_W-1:0]  gx,
      input logic signed [COORD_W-1:0]  gy,
      input logic signed [COORD_W-1:0]  gz);
      logic signed [COORD_W-1:0] gu;
      logic signed [COORD_W-1:0] gv;
      gu = (h < H_U_Y) ? gx : gy;
      if (h < H_V_Y) begin
         gv = gy;
      end else if (h == H_V_X0 || h == H_V_X1) begin
         gv = gx;
      end else begin
         gv = gz;
      end
      if (h[0]) begin
         gu = -gu;
      end
      if (h[1]) begin
         gv = -gv;
      end
      return gu + gv;
   endfunction

endpackage

@@ design/gradient_noise_3d_core.sv @@
// Improved 3D gradient noise, fixed point, fully pipelined.
//
// Request beat: taken at a clock edge with start high (busy is always low).
// req_operation selects a permutation table write (req_table_index,
// req_table_value) or a noise evaluation at the Q16.16 point in
// req_x_coord / req_y_coord / req_z_coord.
// Response: one rsp_strobe pulse per evaluation, with rsp_noise_value
// (signed Q3.16, saturated to +-4.0).
// Table writes give no response.
// Throughput: one beat per clock, any mix of writes and evaluations. The
// lookup chain (3 table reads deep) runs on 7 two-port copies of the
// table; a write travels with the beats and updates each copy in the
// stage that reads it, so order is kept exactly.
// csr_we / csr_wdata load cell_mask; write it only when no evaluation is
// in flight.
// Reset clears all beat valid bits and sets cell_mask to 0xFF; table
// contents are unknown until software loads all entries.
// There is no backpressure: the receiver must take every strobe.
module gradient_noise_3d_core #(
   parameter int unsigned TABLE_DEPTH = 256,
   parameter int unsigned FRAC_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_operation,
   input  logic [gn3_pkg::BYTE_W-1:0]          req_table_index,
   input  logic [gn3_pkg::BYTE_W-1:0]          req_table_value,
   input  logic signed [gn3_pkg::COORD_W-1:0]  req_x_coord,
   input  logic signed [gn3_pkg::COORD_W-1:0]  req_y_coord,
   input  logic signed [gn3_pkg::COORD_W-1:0]  req_z_coord,
   output logic                                rsp_strobe,
   output logic signed [gn3_pkg::NOISE_W-1:0]  rsp_noise_value,
   input  logic                                csr_we,
   input  logic [gn3_pkg::BYTE_W-1:0]          csr_wdata
);

   localparam int unsigned F  = FRAC_BITS;
   localparam int unsigned CW = gn3_pkg::COORD_W;
   localparam int unsigned BW = gn3_pkg::BYTE_W;
   localparam int unsigned GW = F + 3;
   localparam int unsigned DW = F + 4;
   localparam logic signed [CW-1:0] ONE_C = CW'(1) << F;

   logic [BW-1:0] cell_mask_ff;

   logic [CW-1:0]                 coord [3];
   logic [gn3_pkg::WRAP_W-1:0]    windex_w;
   gn3_pkg::beat_ctl_type         ctl1_in, ctl1_ff, ctl4;
   logic [BW-1:0]                 cell1_ff [3];
   logic [F-1:0]                  frac1_ff [3];
   logic [F-1:0]                  frac_d_ff [3][3];  // [stage 2..4][axis]
   logic [F:0]                    fade [3];
   logic [3:0]                    hash_nib [8];

   logic signed [CW-1:0]          off [3][2];
   logic signed [CW-1:0]          gdot;
   logic signed [GW-1:0]          gval [8];
   logic signed [GW-1:0]          lo [4];
   logic signed [DW-1:0]          df [4];

   // no backpressure: every beat is accepted
   assign busy = 1'b0;

   // -------- config --------
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_mask_ff <= gn3_pkg::CELL_MASK_RESET;
      end else if (csr_we) begin
         cell_mask_ff <= csr_wdata;
      end
   end

   // -------- stage 1: split coordinates, wrap write index --------
   assign coord[0] = req_x_coord;
   assign coord[1] = req_y_coord;
   assign coord[2] = req_z_coord;

   assign windex_w = gn3_pkg::wrap_index(gn3_pkg::WRAP_W'(req_table_index), TABLE_DEPTH);

   always_comb begin
      ctl1_in.valid    = start & ~busy;
      ctl1_in.is_write = (gn3_pkg::op_type'(req_operation) == gn3_pkg::OP_WRITE);
      ctl1_in.windex   = windex_w[BW-1:0];
      ctl1_in.wvalue   = req_table_value;
   end

   always_ff @(posedge clock) begin
      ctl1_ff <= reset ? '0 : ctl1_in;
      for (int a = 0; a < 3; a++) begin
         cell1_ff[a]     <= coord[a][F +: BW] & cell_mask_ff;
         frac1_ff[a]     <= coord[a][F-1:0];
         frac_d_ff[0][a] <= frac1_ff[a];
         frac_d_ff[1][a] <= frac_d_ff[0][a];
         frac_d_ff[2][a] <= frac_d_ff[1][a];
      end
   end

   // -------- fade curves (4 stages, aligned with blend entry) --------
   for (genvar a = 0; a < 3; a++) begin : g_fade
      gn3_fade #(.FRAC_BITS(FRAC_BITS)) u_fade (
         .clock    (clock),
         .f_in     (frac1_ff[a]),
         .fade_out (fade[a])
      );
   end

   // -------- stages 2-4: permutation lookups --------
   gn3_hash #(.TABLE_DEPTH(TABLE_DEPTH)) u_hash (
      .clock    (clock),
      .reset    (reset),
      .ctl_in   (ctl1_ff),
      .xi       (cell1_ff[0]),
      .yi       (cell1_ff[1]),
      .zi       (cell1_ff[2]),
      .ctl_out  (ctl4),
      .hash_nib (hash_nib)
   );

   // -------- stage 4: corner gradients --------
   // corner i sits at offset (i[0], i[1], i[2]) in (x, y, z)
   always_comb begin
      gdot = '0;
      for (int a = 0; a < 3; a++) begin
         off[a][0] = $signed(CW'(frac_d_ff[2][a]));
         off[a][1] = off[a][0] - ONE_C;
      end
      for (int i = 0; i < 8; i++) begin
         gdot    = gn3_pkg::grad_dot(hash_nib[i], off[0][i[0]], off[1][i[1]],
                                     off[2][i[2]]);
         gval[i] = gdot[GW-1:0];
      end
      for (int j = 0; j < 4; j++) begin
         lo[j] = gval[2*j];
         df[j] = DW'(gval[2*j+1]) - DW'(gval[2*j]);
      end
   end

   // -------- stages 5-11: trilinear blend and saturation --------
   gn3_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clock    (clock),
      .reset    (reset),
      .valid_in (ctl4.valid & ~ctl4.is_write),
      .lo_in    (lo),
      .df_in    (df),
      .u_in     (fade[0]),
      .v_in     (fade[1]),
      .w_in     (fade[2]),
      .strobe   (rsp_strobe),
      .noise    (rsp_noise_value)
   );

endmodule

@@ design/gn3_perm_mem.sv @@
module gn3_perm_mem #(
   parameter int unsigned DEPTH = 256,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [gn3_pkg::BYTE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]          rd_addr_a,
   input  logic [ADDR_W-1:0]          rd_addr_b,
   output logic [gn3_pkg::BYTE_W-1:0] rd_data_a,
   output logic [gn3_pkg::BYTE_W-1:0] rd_data_b
);

   logic [gn3_pkg::BYTE_W-1:0] table_ff [DEPTH];
   logic [gn3_pkg::BYTE_W-1:0] rd_a_ff;
   logic [gn3_pkg::BYTE_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= table_ff[rd_addr_a];
      rd_b_ff <= table_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ design/gn3_fade.sv @@
module gn3_fade #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic [FRAC_BITS-1:0] f_in,
   output logic [FRAC_BITS:0]   fade_out
);

   localparam int unsigned F     = FRAC_BITS;
   localparam int unsigned SQ_W  = 2 * F;
   localparam int unsigned SUM_W = 2 * F + 5;
   localparam int unsigned INN_W = F + 4;
   localparam int unsigned RAW_W = 2 * F + 4;
   localparam logic [SUM_W-1:0] TEN_ONE_SQ = SUM_W'(gn3_pkg::FADE_C10) << (2 * F);
   localparam logic [INN_W-1:0] ONE_W      = INN_W'(1) << F;

   logic [SQ_W-1:0]  sq_in,    sq_ff;
   logic [F-1:0]     f1_ff;
   logic [SUM_W-1:0] poly;
   logic [INN_W-1:0] inner_in, inner_ff;
   logic [SQ_W-1:0]  prod_in,  prod_ff;
   logic [RAW_W-1:0] raw_in,   raw_ff;
   logic [INN_W-1:0] scaled;
   logic [F:0]       fade_in,  fade_ff;

   // stage 1: t^2
   assign sq_in = SQ_W'(f_in) * SQ_W'(f_in);

   // stage 2: inner polynomial, t^3 product
   assign poly = SUM_W'(gn3_pkg::FADE_C6) * SUM_W'(sq_ff) + TEN_ONE_SQ
               - ((SUM_W'(gn3_pkg::FADE_C15) * SUM_W'(f1_ff)) << F);
   assign inner_in = poly[F +: INN_W];
   assign prod_in  = SQ_W'(sq_ff[SQ_W-1:F]) * SQ_W'(f1_ff);

   // stage 3: t^3 * inner
   assign raw_in = RAW_W'(prod_ff[SQ_W-1:F]) * RAW_W'(inner_ff);

   // stage 4: scale and clamp to one
   assign scaled  = raw_ff[F +: INN_W];
   assign fade_in = (scaled > ONE_W) ? ONE_W[F:0] : scaled[F:0];

   always_ff @(posedge clock) begin
      sq_ff    <= sq_in;
      f1_ff    <= f_in;
      inner_ff <= inner_in;
      prod_ff  <= prod_in;
      raw_ff   <= raw_in;
      fade_ff  <= fade_in;
   end

   assign fade_out = fade_ff;

endmodule

@@ design/gn3_hash.sv @@
module gn3_hash #(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gn3_pkg::beat_ctl_type      ctl_in,
   input  logic [gn3_pkg::BYTE_W-1:0] xi,
   input  logic [gn3_pkg::BYTE_W-1:0] yi,
   input  logic [gn3_pkg::BYTE_W-1:0] zi,
   output gn3_pkg::beat_ctl_type      ctl_out,
   output logic [3:0]                 hash_nib [8]
);

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned WW = gn3_pkg::WRAP_W;
   localparam int unsigned BW = gn3_pkg::BYTE_W;

   gn3_pkg::beat_ctl_type ctl2_ff, ctl3_ff, ctl4_ff;
   logic [BW-1:0] yi2_ff, zi2_ff, zi3_ff;

   logic [WW-1:0] x0_w, x1_w;
   logic [BW-1:0] a_val, b_val;
   logic [WW-1:0] ay0_w, ay1_w, by0_w, by1_w;
   logic [BW-1:0] pa, pa1, pb, pb1;
   logic [WW-1:0] aa, ab, ba, bb;
   logic [WW-1:0] lo_raw [4];
   logic [WW-1:0] hi_raw [4];
   logic [BW-1:0] rd8 [8];

   // stage 1: a = P[x], b = P[x+1]
   assign x0_w = gn3_pkg::wrap_index(WW'(xi), TABLE_DEPTH);
   assign x1_w = gn3_pkg::wrap_index(WW'(xi) + WW'(1), TABLE_DEPTH);

   gn3_perm_mem #(.DEPTH(TABLE_DEPTH)) u_mem_x (
      .clock     (clock),
      .wr_en     (ctl_in.valid & ctl_in.is_write),
      .wr_addr   (ctl_in.windex[AW-1:0]),
      .wr_data   (ctl_in.wvalue),
      .rd_addr_a (x0_w[AW-1:0]),
      .rd_addr_b (x1_w[AW-1:0]),
      .rd_data_a (a_val),
      .rd_data_b (b_val)
   );

   // stage 2: P[a+y], P[a+y+1], P[b+y], P[b+y+1]
   assign ay0_w = gn3_pkg::wrap_index(WW'(a_val) + WW'(yi2_ff), TABLE_DEPTH);
   assign ay1_w = gn3_pkg::wrap_index(WW'(a_val) + WW'(yi2_ff) + WW'(1), TABLE_DEPTH);
   assign by0_w = gn3_pkg::wrap_index(WW'(b_val) + WW'(yi2_ff), TABLE_DEPTH);
   assign by1_w = gn3_pkg::wrap_index(WW'(b_val) + WW'(yi2_ff) + WW'(1), TABLE_DEPTH);

   gn3_perm_mem #(.DEPTH(TABLE_DEPTH)) u_mem_ya (
      .clock     (clock),
      .wr_en     (ctl2_ff.valid & ctl2_ff.is_write),
      .wr_addr   (ctl2_ff.windex[AW-1:0]),
      .wr_data   (ctl2_ff.wvalue),
      .rd_addr_a (ay0_w[AW-1:0]),
      .rd_addr_b (ay1_w[AW-1:0]),
      .rd_data_a (pa),
      .rd_data_b (pa1)
   );

   gn3_perm_mem #(.DEPTH(TABLE_DEPTH)) u_mem_yb (
      .clock     (clock),
      .wr_en     (ctl2_ff.valid & ctl2_ff.is_write),
      .wr_addr   (ctl2_ff.windex[AW-1:0]),
      .wr_data   (ctl2_ff.wvalue),
      .rd_addr_a (by0_w[AW-1:0]),
      .rd_addr_b (by1_w[AW-1:0]),
      .rd_data_a (pb),
      .rd_data_b (pb1)
   );

   // stage 3: eight corner hashes; bank j serves corners 2j and 2j+1
   assign aa = WW'(pa)  + WW'(zi3_ff);
   assign ab = WW'(pa1) + WW'(zi3_ff);
   assign ba = WW'(pb)  + WW'(zi3_ff);
   assign bb = WW'(pb1) + WW'(zi3_ff);

   always_comb begin
      lo_raw[0] = aa;            hi_raw[0] = ba;
      lo_raw[1] = ab;            hi_raw[1] = bb;
      lo_raw[2] = aa + WW'(1);   hi_raw[2] = ba + WW'(1);
      lo_raw[3] = ab + WW'(1);   hi_raw[3] = bb + WW'(1);
   end

   for (genvar j = 0; j < 4; j++) begin : g_corner_bank
      logic [WW-1:0] lo_w, hi_w;
      assign lo_w = gn3_pkg::wrap_index(lo_raw[j], TABLE_DEPTH);
      assign hi_w = gn3_pkg::wrap_index(hi_raw[j], TABLE_DEPTH);
      gn3_perm_mem #(.DEPTH(TABLE_DEPTH)) u_mem_z (
         .clock     (clock),
         .wr_en     (ctl3_ff.valid & ctl3_ff.is_write),
         .wr_addr   (ctl3_ff.windex[AW-1:0]),
         .wr_data   (ctl3_ff.wvalue),
         .rd_addr_a (lo_w[AW-1:0]),
         .rd_addr_b (hi_w[AW-1:0]),
         .rd_data_a (rd8[2*j]),
         .rd_data_b (rd8[2*j+1])
      );
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         hash_nib[i] = rd8[i][3:0];
      end
   end

   always_ff @(posedge clock) begin
      ctl2_ff <= reset ? '0 : ctl_in;
      ctl3_ff <= reset ? '0 : ctl2_ff;
      ctl4_ff <= reset ? '0 : ctl3_ff;
      yi2_ff  <= yi;
      zi2_ff  <= zi;
      zi3_ff  <= zi2_ff;
   end

   assign ctl_out = ctl4_ff;

endmodule

@@ design/gn3_blend.sv @@
module gn3_blend #(
   parameter int unsigned FRAC_BITS = 16,
   localparam int unsigned GW = FRAC_BITS + 3,
   localparam int unsigned DW = FRAC_BITS + 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               valid_in,
   input  logic signed [GW-1:0]               lo_in [4],
   input  logic signed [DW-1:0]               df_in [4],
   input  logic [FRAC_BITS:0]                 u_in,
   input  logic [FRAC_BITS:0]                 v_in,
   input  logic [FRAC_BITS:0]                 w_in,
   output logic                               strobe,
   output logic signed [gn3_pkg::NOISE_W-1:0] noise
);

   localparam int unsigned F  = FRAC_BITS;
   localparam int unsigned TW = F + 2;
   localparam int unsigned PW = TW + DW;
   localparam int unsigned NW = gn3_pkg::NOISE_W;

   logic vld5_ff, vld6_ff, vld7_ff, vld8_ff, vld9_ff, vld10_ff, strobe_ff;

   logic signed [GW-1:0] lo5_ff [4];
   logic signed [DW-1:0] df5_ff [4];
   logic signed [PW-1:0] p_in [4];
   logic signed [PW-1:0] p6_ff [4];
   logic signed [GW-1:0] lo6_ff [4];
   logic [F:0]           v6_ff, w6_ff, v7_ff, w7_ff, w8_ff, w9_ff;
   logic signed [PW-1:0] p_sh [4];
   logic signed [GW-1:0] l_val [4];
   logic signed [DW-1:0] dv_in [2];
   logic signed [GW-1:0] l0_7_ff, l2_7_ff, l0_8_ff, l2_8_ff;
   logic signed [DW-1:0] dv7_ff [2];
   logic signed [PW-1:0] q_in [2];
   logic signed [PW-1:0] q8_ff [2];
   logic signed [PW-1:0] q_sh [2];
   logic signed [GW-1:0] m0, m1;
   logic signed [DW-1:0] dw_in;
   logic signed [GW-1:0] m0_9_ff, m0_10_ff;
   logic signed [DW-1:0] dw9_ff;
   logic signed [PW-1:0] pw_in, pw10_ff, pw_sh;
   logic signed [GW-1:0] r_val;
   logic signed [31:0]   r_wide;
   logic signed [NW-1:0] noise_in, noise_ff;

   // x blends: weight times span
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         p_in[i] = $signed({1'b0, u_in}) * df5_ff[i];
      end
   end

   // x blends done, y spans
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         p_sh[i]  = p6_ff[i] >>> F;
         l_val[i] = lo6_ff[i] + p_sh[i][GW-1:0];
      end
      dv_in[0] = DW'(l_val[1]) - DW'(l_val[0]);
      dv_in[1] = DW'(l_val[3]) - DW'(l_val[2]);
   end

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         q_in[i] = $signed({1'b0, v7_ff}) * dv7_ff[i];
      end
   end

   // y blends done, z span
   always_comb begin
      q_sh[0] = q8_ff[0] >>> F;
      q_sh[1] = q8_ff[1] >>> F;
      m0      = l0_8_ff + q_sh[0][GW-1:0];
      m1      = l2_8_ff + q_sh[1][GW-1:0];
      dw_in   = DW'(m1) - DW'(m0);
   end

   assign pw_in = $signed({1'b0, w9_ff}) * dw9_ff;

   // z blend and saturation
   always_comb begin
      pw_sh  = pw10_ff >>> F;
      r_val  = m0_10_ff + pw_sh[GW-1:0];
      r_wide = 32'(r_val);
      if (r_wide > gn3_pkg::NOISE_LIMIT) begin
         noise_in = NW'(gn3_pkg::NOISE_LIMIT);
      end else if (r_wide < -gn3_pkg::NOISE_LIMIT) begin
         noise_in = NW'(-gn3_pkg::NOISE_LIMIT);
      end else begin
         noise_in = r_wide[NW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      lo5_ff   <= lo_in;
      df5_ff   <= df_in;
      p6_ff    <= p_in;
      lo6_ff   <= lo5_ff;
      v6_ff    <= v_in;
      w6_ff    <= w_in;
      l0_7_ff  <= l_val[0];
      l2_7_ff  <= l_val[2];
      dv7_ff   <= dv_in;
      v7_ff    <= v6_ff;
      w7_ff    <= w6_ff;
      q8_ff    <= q_in;
      l0_8_ff  <= l0_7_ff;
      l2_8_ff  <= l2_7_ff;
      w8_ff    <= w7_ff;
      m0_9_ff  <= m0;
      dw9_ff   <= dw_in;
      w9_ff    <= w8_ff;
      m0_10_ff <= m0_9_ff;
      pw10_ff  <= pw_in;
      noise_ff <= noise_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld5_ff   <= 1'b0;
         vld6_ff   <= 1'b0;
         vld7_ff   <= 1'b0;
         vld8_ff   <= 1'b0;
         vld9_ff   <= 1'b0;
         vld10_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         vld5_ff   <= valid_in;
         vld6_ff   <= vld5_ff;
         vld7_ff   <= vld6_ff;
         vld8_ff   <= vld7_ff;
         vld9_ff   <= vld8_ff;
         vld10_ff  <= vld9_ff;
         strobe_ff <= vld10_ff;
      end
   end

   assign strobe = strobe_ff;
   assign noise  = noise_ff;

endmodule

@@ design/gn3_checker.sv @@
module gn3_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               req_operation,
   input logic                               rsp_strobe,
   input logic signed [gn3_pkg::NOISE_W-1:0] rsp_noise_value
);

   localparam int unsigned LATENCY = 11;

   logic eval_beat;
   assign eval_beat = start & ~busy & ~reset &
                      (gn3_pkg::op_type'(req_operation) == gn3_pkg::OP_EVAL);

   a_eval_gets_strobe: assert property (@(posedge clock) disable iff (reset)
      eval_beat |-> ##LATENCY rsp_strobe)
      else $error("evaluation beat produced no response");

   a_strobe_has_eval: assert property (@(posedge clock)
      rsp_strobe |-> $past(eval_beat, LATENCY))
      else $error("response without matching evaluation beat");

   a_noise_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (32'(rsp_noise_value) <= gn3_pkg::NOISE_LIMIT &&
                      32'(rsp_noise_value) >= -gn3_pkg::NOISE_LIMIT))
      else $error("noise value outside saturation range");

   a_never_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");

endmodule

bind gradient_noise_3d_core gn3_checker u_gn3_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_operation   (req_operation),
   .rsp_strobe      (rsp_strobe),
   .rsp_noise_value (rsp_noise_value)
);
